>>> src/gses_pkg.sv
`default_nettype none

package gses_pkg;

  // Frame geometry limits
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MinDim    = 3;

  // Position counters and register widths
  localparam int unsigned ColW    = $clog2(MaxWidth);
  localparam int unsigned RowW    = $clog2(MaxHeight);
  localparam int unsigned WidthW  = 12;
  localparam int unsigned HeightW = 13;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 2'd0,
    RegImageHeight = 2'd1
  } cfg_reg_e;

  // Pixel arithmetic
  localparam int unsigned PixW  = 8;
  localparam int unsigned WgtW  = 16;
  localparam int unsigned ProdW = PixW + WgtW;
  localparam int unsigned SumW  = PixW + 2;
  localparam int unsigned LineW = 2 * PixW;

  // Luma weights, 16-bit fixed point, summing to 65536
  localparam logic [WgtW-1:0] WeightRed   = 16'd13933;
  localparam logic [WgtW-1:0] WeightGreen = 16'd46871;
  localparam logic [WgtW-1:0] WeightBlue  = 16'd4732;

  // Result buffer
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic            frame_start;
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] edge_magnitude;
    logic            last_of_frame;
  } pix_out_t;

  // Status of the result buffer as seen by the pipeline
  typedef struct packed {
    logic                out_valid;
    logic [FifoCntW-1:0] count;
  } fifo_status_t;

endpackage

`default_nettype wire

>>> src/gses_ram.sv
`default_nettype none

module gses_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/gses_result_fifo.sv
`default_nettype none

module gses_result_fifo (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  input  wire gses_pkg::pix_out_t       push_data_i,
  input  wire logic                     out_stall_i,
  output gses_pkg::pix_out_t            out_data_o,
  output gses_pkg::fifo_status_t        status_o
);

  gses_pkg::pix_out_t buf_q [gses_pkg::FifoDepth];

  logic [gses_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [gses_pkg::FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [gses_pkg::FifoCntW-1:0] count_q, count_d;
  logic                          pop;
  logic                          not_empty;

  assign not_empty = (count_q != '0);
  assign pop       = not_empty && !out_stall_i;

  // Pointer and fill bookkeeping; the caller never pushes into a full buffer
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + gses_pkg::FifoPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + gses_pkg::FifoPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + gses_pkg::FifoCntW'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - gses_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_data_o          = buf_q[rd_ptr_q];
  assign status_o.out_valid  = not_empty;
  assign status_o.count      = count_q;

endmodule

`default_nettype wire

>>> src/grey_sobel_edge_stream_top.sv
// Streaming 3x3 Sobel edge detector on colour video. Pixels enter in raster
// order at one per clock unless stalled; each is turned into luma, pushed
// through a two-row line store and a 3x3 window, and for every interior pixel
// (column >= 2, row >= 2) one beat leaves with the saturated |Gx|+|Gy| of the
// window centre. Border pixels give no beat. A result passes the stage 1
// registers, window, stage 3 registers and result buffer. Throughput is one
// pixel per clock unless stalled, set by the single line RAM, which is read for
// a pixel on the accept edge and written back on the next one. An 8-beat result
// buffer lets the input keep flowing while the output is stalled; in_stall_o
// rises once the buffer plus the beats still in the pipeline could fill it. The
// line store has no reset and needs no clearing pass: a fresh frame must fill
// two rows before interior output, and line-store entries not yet written since
// reset read as undefined. Width and height are clamped to 3..2048 and 3..4096
// and may be changed only while the block is idle.
`default_nettype none

module grey_sobel_edge_stream_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // pixel input
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire gses_pkg::pix_in_t               in_data_i,
  // result output
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output gses_pkg::pix_out_t                   out_data_o,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [gses_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [gses_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned ColW    = gses_pkg::ColW;
  localparam int unsigned RowW    = gses_pkg::RowW;
  localparam int unsigned WidthW  = gses_pkg::WidthW;
  localparam int unsigned HeightW = gses_pkg::HeightW;
  localparam int unsigned PixW    = gses_pkg::PixW;
  localparam int unsigned ProdW   = gses_pkg::ProdW;
  localparam int unsigned SumW    = gses_pkg::SumW;
  localparam int unsigned LineW   = gses_pkg::LineW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(640);
      height_q <= HeightW'(480);
    end else if (cfg_valid_i) begin
      case (gses_pkg::cfg_reg_e'(cfg_index_i))
        gses_pkg::RegImageWidth:  width_q  <= cfg_data_i[WidthW-1:0];
        gses_pkg::RegImageHeight: height_q <= cfg_data_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry
  logic [WidthW-1:0]  width_use;
  logic [HeightW-1:0] height_use;

  always_comb begin
    if (width_q < WidthW'(gses_pkg::MinDim)) begin
      width_use = WidthW'(gses_pkg::MinDim);
    end else if (width_q > WidthW'(gses_pkg::MaxWidth)) begin
      width_use = WidthW'(gses_pkg::MaxWidth);
    end else begin
      width_use = width_q;
    end
    if (height_q < HeightW'(gses_pkg::MinDim)) begin
      height_use = HeightW'(gses_pkg::MinDim);
    end else if (height_q > HeightW'(gses_pkg::MaxHeight)) begin
      height_use = HeightW'(gses_pkg::MaxHeight);
    end else begin
      height_use = height_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position of the arriving pixel
  logic                accept;
  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [ColW-1:0]     col_base, cur_col;
  logic [HeightW-1:0]  row_base, row_inc, row_nxt;
  logic [RowW-1:0]     cur_row;
  logic [WidthW-1:0]   col_nxt;
  logic                col_wrap;
  logic                cur_emit, cur_last;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    col_base = in_data_i.frame_start ? '0 : col_q;
    row_base = in_data_i.frame_start ? '0 : HeightW'(row_q);
    // held column past a narrowed width moves to the next row
    col_wrap = (WidthW'(col_base) >= width_use);
    cur_col  = col_wrap ? '0 : col_base;
    row_inc  = col_wrap ? row_base + HeightW'(1) : row_base;
    cur_row  = (row_inc >= height_use) ? '0 : row_inc[RowW-1:0];

    cur_emit = (cur_col >= ColW'(2)) && (cur_row >= RowW'(2));
    cur_last = (WidthW'(cur_col) == width_use - WidthW'(1)) &&
               (HeightW'(cur_row) == height_use - HeightW'(1));

    // position of the following pixel
    col_nxt = WidthW'(cur_col) + WidthW'(1);
    row_nxt = HeightW'(cur_row) + HeightW'(1);
    if (col_nxt >= width_use) begin
      col_d = '0;
      row_d = (row_nxt >= height_use) ? '0 : row_nxt[RowW-1:0];
    end else begin
      col_d = col_nxt[ColW-1:0];
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers: weighted colour products, position flags
  logic             s1_valid_q, s1_emit_q, s1_last_q;
  logic [ColW-1:0]  s1_col_q;
  logic [ProdW-1:0] s1_prod_r_q, s1_prod_g_q, s1_prod_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q   <= cur_emit;
      s1_last_q   <= cur_last;
      s1_col_q    <= cur_col;
      s1_prod_r_q <= ProdW'(in_data_i.red)   * ProdW'(gses_pkg::WeightRed);
      s1_prod_g_q <= ProdW'(in_data_i.green) * ProdW'(gses_pkg::WeightGreen);
      s1_prod_b_q <= ProdW'(in_data_i.blue)  * ProdW'(gses_pkg::WeightBlue);
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: upper row in the high byte, lower row in the low byte.
  // Read on the accept edge, written back from stage 1.
  logic [LineW-1:0] line_rdata;
  logic [LineW-1:0] line_wdata;

  gses_ram #(
    .Width (LineW),
    .Depth (gses_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (line_wdata),
    .re_i    (accept),
    .raddr_i (cur_col),
    .rdata_o (line_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1 logic: luma, forwarding, window shift
  logic [PixW-1:0] win_q [3][3];
  logic            s2_valid_q, s2_emit_q, s2_last_q;
  logic [ColW-1:0] s2_col_q;

  logic [ProdW-1:0] grey_sum;
  logic [PixW-1:0]  grey;
  logic [PixW-1:0]  above2, above1;
  logic             fwd_hit;

  always_comb begin
    grey_sum = s1_prod_r_q + s1_prod_g_q + s1_prod_b_q;
    grey     = grey_sum[ProdW-1 -: PixW];
    // previous pixel wrote the same column on the edge of this read
    fwd_hit  = s2_valid_q && (s2_col_q == s1_col_q);
    above2   = fwd_hit ? win_q[1][2] : line_rdata[LineW-1 -: PixW];
    above1   = fwd_hit ? win_q[2][2] : line_rdata[PixW-1:0];
    line_wdata = {above1, grey};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= win_q[k][2];
      end
      win_q[0][2] <= above2;
      win_q[1][2] <= above1;
      win_q[2][2] <= grey;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_emit_q <= s1_emit_q;
      s2_last_q <= s1_last_q;
      s2_col_q  <= s1_col_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: Sobel gradients from the window
  logic [SumW-1:0] sum_right, sum_left, sum_top, sum_bot;
  logic [SumW-1:0] grad_x, grad_y;

  always_comb begin
    sum_right = SumW'(win_q[0][2]) + (SumW'(win_q[1][2]) << 1) + SumW'(win_q[2][2]);
    sum_left  = SumW'(win_q[0][0]) + (SumW'(win_q[1][0]) << 1) + SumW'(win_q[2][0]);
    sum_top   = SumW'(win_q[0][0]) + (SumW'(win_q[0][1]) << 1) + SumW'(win_q[0][2]);
    sum_bot   = SumW'(win_q[2][0]) + (SumW'(win_q[2][1]) << 1) + SumW'(win_q[2][2]);
    grad_x    = (sum_right >= sum_left) ? sum_right - sum_left : sum_left - sum_right;
    grad_y    = (sum_top >= sum_bot) ? sum_top - sum_bot : sum_bot - sum_top;
  end

  logic            s3_valid_q, s3_last_q;
  logic [SumW-1:0] s3_gx_q, s3_gy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q && s2_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s2_emit_q) begin
      s3_last_q <= s2_last_q;
      s3_gx_q   <= grad_x;
      s3_gy_q   <= grad_y;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: magnitude with saturation, into the result buffer
  logic [SumW:0]          mag_sum;
  gses_pkg::pix_out_t     push_data;
  gses_pkg::fifo_status_t fifo_status;

  always_comb begin
    mag_sum = (SumW + 1)'(s3_gx_q) + (SumW + 1)'(s3_gy_q);
    push_data.edge_magnitude = (mag_sum > (SumW + 1)'({PixW{1'b1}})) ?
                               {PixW{1'b1}} : mag_sum[PixW-1:0];
    push_data.last_of_frame  = s3_last_q;
  end

  gses_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid_q),
    .push_data_i (push_data),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .status_o    (fifo_status)
  );

  assign out_valid_o = fifo_status.out_valid;

  // Stall when buffered plus in-flight results could fill the buffer
  logic [gses_pkg::FifoCntW:0] pending;

  always_comb begin
    pending = (gses_pkg::FifoCntW + 1)'(fifo_status.count) +
              (gses_pkg::FifoCntW + 1)'(s1_valid_q && s1_emit_q) +
              (gses_pkg::FifoCntW + 1)'(s2_valid_q && s2_emit_q) +
              (gses_pkg::FifoCntW + 1)'(s3_valid_q);
    in_stall_o = (pending >= (gses_pkg::FifoCntW + 1)'(gses_pkg::FifoDepth));
  end

endmodule

`default_nettype wire
